// File: hw/rtl/assert_macros.svh
// assertion helpers included by the page table walker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/sv39ptw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv39ptw_pkg
// Shared types and constants of the Sv39 page table walker.
// ----------------------------------------------------------------------------
package sv39ptw_pkg;

  localparam int IDX_W     = 9;
  localparam int ENTRIES   = 512;
  localparam int PPN_W     = 44;
  localparam int FLAGS_W   = 10;
  localparam int VPN_W     = 27;
  localparam int ENTRY_W   = PPN_W + FLAGS_W;
  localparam int ALLOC_W   = 5;
  localparam logic [ALLOC_W-1:0] ALLOC_MAX = 5'd31;

  typedef enum logic [1:0] {
    CMD_MAP    = 2'd0,
    CMD_UNMAP  = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STS_DONE     = 3'd0,
    STS_REMAPPED = 3'd1,
    STS_NO_PAGE  = 3'd2,
    STS_NO_PATH  = 3'd3,
    STS_INVALID  = 3'd4,
    STS_BAD_PTR  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_ROOT      = 2'd0,
    CFG_FIRST     = 2'd1,
    CFG_POOL_BASE = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_ZERO,
    ST_LINK,
    ST_RESP
  } state_t;

endpackage

// File: hw/rtl/sv39_page_table_walker.sv
`timescale 1ns / 1ps
// After reset the block sweeps its table store to zero, one entry a cycle,
// and takes no item until that is done. An item then walks three table
// levels, each a read state and an evaluate state (ST_READ, ST_EVAL) on the
// single-port store, between the accept in ST_IDLE and the result in ST_RESP.
// Every table page a map allocates adds the zeroing of that page in ST_ZERO,
// through the same port, and the write of the link entry in ST_LINK.
// ----------------------------------------------------------------------------
// sv39_page_table_walker
// Maps, unmaps and looks up Sv39 virtual pages in a local table store.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sv39_page_table_walker
  import sv39ptw_pkg::*;
#(
  parameter int NUM_TABLE_PAGES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [PPN_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          command,
  input  logic [VPN_W-1:0]    virt_page,
  input  logic [PPN_W-1:0]    phys_page,
  input  logic [FLAGS_W-1:0]  flags,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PPN_W-1:0]    phys_page_out,
  output logic                found,
  output logic [2:0]          status
);

  localparam int PAGE_W = $clog2(NUM_TABLE_PAGES);
  localparam int ADDR_W = PAGE_W + IDX_W;
  localparam int DEPTH  = NUM_TABLE_PAGES * ENTRIES;
  localparam logic [9:0] NUM_L = 10'(NUM_TABLE_PAGES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [ENTRY_W-1:0] mem [DEPTH];

  state_t state, state_next;
  logic [1:0]          lvl, lvl_next;
  logic [PAGE_W-1:0]   page, page_next;
  logic [PAGE_W-1:0]   alloc_page, alloc_page_next;
  logic [IDX_W-1:0]    zcnt, zcnt_next;
  logic [ADDR_W-1:0]   clr_cnt, clr_cnt_next;
  cmd_t                cmd;
  logic [VPN_W-1:0]    vpn;
  logic [PPN_W-1:0]    pa;
  logic [FLAGS_W-1:0]  fl;
  logic [PPN_W-1:0]    res_pa, res_pa_next;
  logic                res_found, res_found_next;
  status_t             res_status, res_status_next;
  logic                out_valid_next;
  logic                out_load;
  logic [ALLOC_W-1:0]  pages_allocated, pages_allocated_next;
  logic [3:0]          root_page;
  logic [4:0]          first_free_page;
  logic [PPN_W-1:0]    pool_base_ppn;
  logic [ENTRY_W-1:0]  rdata;

  logic                rd_en;
  logic                mem_we;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0]  wr_data;
  logic [IDX_W-1:0]    slice;
  logic [ADDR_W-1:0]   slot_addr;
  logic [PPN_W:0]      diff;
  logic                ptr_bad;
  logic [5:0]          nxt;
  logic [PPN_W-1:0]    link_ppn;
  logic                in_acc;

  assign in_acc = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    case (lvl)
      2'd2:    slice = vpn[26:18];
      2'd1:    slice = vpn[17:9];
      default: slice = vpn[8:0];
    endcase
  end

  assign slot_addr = {page, slice};
  assign diff      = {1'b0, rdata[ENTRY_W-1:FLAGS_W]} - {1'b0, pool_base_ppn};
  assign ptr_bad   = diff[PPN_W] || (diff[PPN_W-1:0] >= PPN_W'(NUM_TABLE_PAGES));
  assign nxt       = {1'b0, first_free_page} + {1'b0, pages_allocated};
  assign link_ppn  = pool_base_ppn + PPN_W'(alloc_page);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      root_page       <= 4'd0;
      first_free_page <= 5'd1;
      pool_base_ppn   <= 44'd524288;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROOT:      root_page       <= cfg_data[3:0];
        CFG_FIRST:     first_free_page <= cfg_data[4:0];
        CFG_POOL_BASE: pool_base_ppn   <= cfg_data;
        default: ;
      endcase
    end
  end

  // table store, one read or one write per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[slot_addr];
  end

  always_comb begin
    state_next           = state;
    lvl_next             = lvl;
    page_next            = page;
    alloc_page_next      = alloc_page;
    zcnt_next            = zcnt;
    clr_cnt_next         = clr_cnt;
    res_pa_next          = res_pa;
    res_found_next       = res_found;
    res_status_next      = res_status;
    pages_allocated_next = pages_allocated;
    rd_en                = 1'b0;
    mem_we               = 1'b0;
    wr_addr              = slot_addr;
    wr_data              = '0;
    out_load             = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        wr_addr      = clr_cnt;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == LAST_ADDR) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          res_pa_next     = '0;
          res_found_next  = 1'b0;
          res_status_next = STS_DONE;
          lvl_next        = 2'd2;
          page_next       = PAGE_W'(root_page);
          if (cmd_t'(command) == CMD_NONE) begin
            state_next = ST_RESP;
          end else if ({6'd0, root_page} >= NUM_L) begin
            res_status_next = STS_BAD_PTR;
            state_next      = ST_RESP;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        rd_en      = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (lvl != 2'd0) begin
          if (rdata[0]) begin
            if (ptr_bad) begin
              res_status_next = STS_BAD_PTR;
              state_next      = ST_RESP;
            end else begin
              page_next  = diff[PAGE_W-1:0];
              lvl_next   = lvl - 2'd1;
              state_next = ST_READ;
            end
          end else if (cmd == CMD_MAP) begin
            if ({4'd0, nxt} >= NUM_L || pages_allocated == ALLOC_MAX) begin
              res_status_next = STS_NO_PAGE;
              state_next      = ST_RESP;
            end else begin
              pages_allocated_next = pages_allocated + 1'b1;
              alloc_page_next      = PAGE_W'(nxt);
              zcnt_next            = '0;
              state_next           = ST_ZERO;
            end
          end else begin
            res_status_next = STS_NO_PATH;
            state_next      = ST_RESP;
          end
        end else begin
          state_next = ST_RESP;
          case (cmd)
            CMD_MAP: begin
              mem_we  = 1'b1;
              wr_data = {pa, fl | 10'd1};
              if (rdata[0]) res_status_next = STS_REMAPPED;
            end
            CMD_UNMAP: begin
              mem_we = 1'b1;
              if (!rdata[0]) res_status_next = STS_INVALID;
            end
            default: begin
              if (rdata[0]) begin
                res_pa_next    = rdata[ENTRY_W-1:FLAGS_W];
                res_found_next = 1'b1;
              end else begin
                res_status_next = STS_INVALID;
              end
            end
          endcase
        end
      end
      ST_ZERO: begin
        // zero the new page before linking, it may be the current one
        mem_we    = 1'b1;
        wr_addr   = {alloc_page, zcnt};
        zcnt_next = zcnt + 1'b1;
        if (zcnt == LAST_IDX) state_next = ST_LINK;
      end
      ST_LINK: begin
        mem_we     = 1'b1;
        wr_data    = {link_ppn, 10'd1};
        page_next  = alloc_page;
        lvl_next   = lvl - 2'd1;
        state_next = ST_READ;
      end
      ST_RESP: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid_next = out_load || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_cnt         <= '0;
      pages_allocated <= '0;
      out_valid       <= 1'b0;
    end else begin
      state           <= state_next;
      clr_cnt         <= clr_cnt_next;
      pages_allocated <= pages_allocated_next;
      out_valid       <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    lvl        <= lvl_next;
    page       <= page_next;
    alloc_page <= alloc_page_next;
    zcnt       <= zcnt_next;
    res_pa     <= res_pa_next;
    res_found  <= res_found_next;
    res_status <= res_status_next;
    if (in_acc) begin
      cmd <= cmd_t'(command);
      vpn <= virt_page;
      pa  <= phys_page;
      fl  <= flags;
    end
    if (out_load) begin
      phys_page_out <= res_pa;
      found         <= res_found;
      status        <= res_status;
    end
  end

  `ASSERT_SAME(a_rw_excl, clk, rst, rd_en, !mem_we)
  `ASSERT_SAME(a_found_ok, clk, rst, out_valid && found, status == STS_DONE)
  `ASSERT_SAME(a_zero_wr, clk, rst, state == ST_ZERO, mem_we && wr_data == '0)
  `ASSERT_NEXT(a_alloc_mono, clk, rst, 1'b1,
               $past(rst) || pages_allocated >= $past(pages_allocated))

endmodule
